### hw/rtl/hashed_reference_count_table_defines.svh
// Assertion macros used by the reference count table sequencer.
`ifndef HASHED_REFERENCE_COUNT_TABLE_DEFINES_SVH
`define HASHED_REFERENCE_COUNT_TABLE_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define HRCT_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("hrct check failed");

// Checks that a consequence holds in the cycle of its cause.
`define HRCT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hrct check failed");

`endif

### hw/rtl/hrct_pkg.sv
// Package with types and constants of the reference count table.
`timescale 1ns / 1ps
`default_nettype none
package hrct_pkg;
    localparam int SLOTS      = 256;
    localparam int COUNT_BITS = 32;
    localparam int AW         = $clog2(SLOTS);
    localparam int PW         = $clog2(SLOTS + 1);

    typedef logic [AW-1:0]         t_addr;
    typedef logic [PW-1:0]         t_ptr;
    typedef logic [COUNT_BITS-1:0] t_count;

    localparam t_ptr   NIL       = t_ptr'(SLOTS);
    localparam t_count COUNT_MAX = '1;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_RELERR = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key_value;
        logic [7:0]  key_type;
    } t_in_item;

    typedef struct packed {
        logic [31:0] ref_count;
        logic        was_released;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_NODE,
        S_INS,
        S_FREE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        bh_re;
        t_addr       bh_raddr;
        logic        bh_we;
        t_addr       bh_waddr;
        t_ptr        bh_wdata;
        logic        nd_re;
        t_addr       nd_raddr;
        logic        key_we;
        t_addr       key_waddr;
        logic [71:0] key_wdata;
        logic        cnt_we;
        t_addr       cnt_waddr;
        t_count      cnt_wdata;
        logic        nxt_we;
        t_addr       nxt_waddr;
        t_ptr        nxt_wdata;
    } t_mem_req;

    typedef struct packed {
        t_ptr        bh_q;
        logic [71:0] key_q;
        t_count      cnt_q;
        t_ptr        nxt_q;
    } t_mem_rsp;
endpackage
`default_nettype wire

### hw/rtl/hashed_reference_count_table.sv
// Top level of the hashed reference count table.
//  channel  | valid    | ready    | payload
//  request  | i_valid  | o_ready  | i_item (operation, key_value, key_type)
//  result   | o_valid  | i_ready  | o_item (ref_count, was_released, status)
// One item at a time: after accept the sequencer reads the bucket head (S_HEAD), walks the
// chain (S_NODE), inserts a node on an add or query miss (S_INS), returns a freed node on a
// release (S_FREE) and ends in S_DONE; a release miss, full table or undefined op ends there.
// After reset a clearing pass loads bucket heads and free links; o_ready stays low.
// A waiting result holds the sequencer until taken; the next item is then accepted.
`timescale 1ns / 1ps
`default_nettype none
module hashed_reference_count_table (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire hrct_pkg::t_in_item  i_item,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output hrct_pkg::t_out_item      o_item
);
    hrct_pkg::t_mem_req w_req;
    hrct_pkg::t_mem_rsp w_rsp;
    logic               w_clr_busy;

    hrct_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item),
        .o_req(w_req), .i_rsp(w_rsp), .i_clr_busy(w_clr_busy)
    );

    hrct_store u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp),
        .o_clr_busy(w_clr_busy)
    );
endmodule
`default_nettype wire

### hw/rtl/hrct_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module hrct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### hw/rtl/hrct_store.sv
// Bucket and node memories with a clearing pass that loads their reset values.
`timescale 1ns / 1ps
`default_nettype none
module hrct_store (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire hrct_pkg::t_mem_req i_req,
    output hrct_pkg::t_mem_rsp     o_rsp,
    output logic                   o_clr_busy
);
    logic                       r_clr_busy;
    hrct_pkg::t_addr            r_clr_addr;
    logic                       w_bh_we;
    hrct_pkg::t_addr            w_bh_waddr;
    hrct_pkg::t_ptr             w_bh_wdata;
    logic                       w_nxt_we;
    hrct_pkg::t_addr            w_nxt_waddr;
    hrct_pkg::t_ptr             w_nxt_wdata;
    hrct_pkg::t_ptr             w_bh_q;
    hrct_pkg::t_count           w_cnt_q;
    hrct_pkg::t_ptr             w_nxt_q;
    logic [71:0]                w_key_q;

    // While clearing, each bucket gets the empty marker and each node links to the next.
    assign w_bh_we     = r_clr_busy || i_req.bh_we;
    assign w_bh_waddr  = r_clr_busy ? r_clr_addr : i_req.bh_waddr;
    assign w_bh_wdata  = r_clr_busy ? hrct_pkg::NIL : i_req.bh_wdata;
    assign w_nxt_we    = r_clr_busy || i_req.nxt_we;
    assign w_nxt_waddr = r_clr_busy ? r_clr_addr : i_req.nxt_waddr;
    assign w_nxt_wdata = r_clr_busy ? hrct_pkg::t_ptr'(r_clr_addr) + hrct_pkg::t_ptr'(1)
                                    : i_req.nxt_wdata;

    hrct_ram #(.WIDTH(hrct_pkg::PW), .DEPTH(hrct_pkg::SLOTS)) u_bh (
        .i_clk(i_clk), .i_we(w_bh_we), .i_waddr(w_bh_waddr),
        .i_wdata(w_bh_wdata), .i_re(i_req.bh_re), .i_raddr(i_req.bh_raddr),
        .o_rdata(w_bh_q)
    );

    hrct_ram #(.WIDTH(72), .DEPTH(hrct_pkg::SLOTS)) u_key (
        .i_clk(i_clk), .i_we(i_req.key_we), .i_waddr(i_req.key_waddr),
        .i_wdata(i_req.key_wdata), .i_re(i_req.nd_re), .i_raddr(i_req.nd_raddr),
        .o_rdata(w_key_q)
    );

    hrct_ram #(.WIDTH(hrct_pkg::COUNT_BITS), .DEPTH(hrct_pkg::SLOTS)) u_cnt (
        .i_clk(i_clk), .i_we(i_req.cnt_we), .i_waddr(i_req.cnt_waddr),
        .i_wdata(i_req.cnt_wdata), .i_re(i_req.nd_re), .i_raddr(i_req.nd_raddr),
        .o_rdata(w_cnt_q)
    );

    hrct_ram #(.WIDTH(hrct_pkg::PW), .DEPTH(hrct_pkg::SLOTS)) u_nxt (
        .i_clk(i_clk), .i_we(w_nxt_we), .i_waddr(w_nxt_waddr),
        .i_wdata(w_nxt_wdata), .i_re(i_req.nd_re), .i_raddr(i_req.nd_raddr),
        .o_rdata(w_nxt_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + hrct_pkg::t_addr'(1);
            if (r_clr_addr == hrct_pkg::t_addr'(hrct_pkg::SLOTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_clr_busy = r_clr_busy;
    assign o_rsp      = {w_bh_q, w_key_q, w_cnt_q, w_nxt_q};
endmodule
`default_nettype wire

### hw/rtl/hrct_ctrl.sv
// Sequencer that walks bucket chains and updates counts and the free list.
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_reference_count_table_defines.svh"
module hrct_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire hrct_pkg::t_in_item  i_item,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output hrct_pkg::t_out_item      o_item,
    output hrct_pkg::t_mem_req       o_req,
    input  wire hrct_pkg::t_mem_rsp  i_rsp,
    input  wire logic                i_clr_busy
);
    hrct_pkg::t_state    r_state, n_state;
    logic [1:0]          r_op;
    logic [63:0]         r_kv;
    logic [7:0]          r_kt;
    hrct_pkg::t_ptr      r_cur, n_cur;
    hrct_pkg::t_ptr      r_pred, n_pred;
    hrct_pkg::t_ptr      r_head, n_head;
    hrct_pkg::t_ptr      r_free, n_free;
    hrct_pkg::t_ptr      r_used, n_used;
    hrct_pkg::t_count    r_cnt, n_cnt;
    logic                r_rel, n_rel;
    logic [1:0]          r_sts, n_sts;
    logic                r_out_vld;
    hrct_pkg::t_out_item r_out;

    logic w_accept;
    logic w_match;
    logic w_full;
    logic w_done_load;

    assign w_accept    = i_valid && o_ready;
    assign w_match     = (i_rsp.key_q == {r_kv, r_kt});
    assign w_full      = (r_used == hrct_pkg::t_ptr'(hrct_pkg::SLOTS)) ||
                         (r_free == hrct_pkg::NIL);
    assign w_done_load = (r_state == hrct_pkg::S_DONE) && (!r_out_vld || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            hrct_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_item.operation inside {hrct_pkg::OP_ADD, hrct_pkg::OP_QUERY,
                                                        hrct_pkg::OP_RELEASE})
                              ? hrct_pkg::S_HEAD : hrct_pkg::S_DONE;
                end
            end
            hrct_pkg::S_HEAD: begin
                if (i_rsp.bh_q != hrct_pkg::NIL) begin
                    n_state = hrct_pkg::S_NODE;
                end else if (r_op == hrct_pkg::OP_RELEASE || w_full) begin
                    n_state = hrct_pkg::S_DONE;
                end else begin
                    n_state = hrct_pkg::S_INS;
                end
            end
            hrct_pkg::S_NODE: begin
                if (w_match) begin
                    n_state = (r_op == hrct_pkg::OP_RELEASE &&
                               i_rsp.cnt_q == hrct_pkg::t_count'(1))
                              ? hrct_pkg::S_FREE : hrct_pkg::S_DONE;
                end else if (i_rsp.nxt_q != hrct_pkg::NIL) begin
                    n_state = hrct_pkg::S_NODE;
                end else if (r_op == hrct_pkg::OP_RELEASE || w_full) begin
                    n_state = hrct_pkg::S_DONE;
                end else begin
                    n_state = hrct_pkg::S_INS;
                end
            end
            hrct_pkg::S_INS:  n_state = hrct_pkg::S_DONE;
            hrct_pkg::S_FREE: n_state = hrct_pkg::S_DONE;
            hrct_pkg::S_DONE: begin
                if (w_done_load) begin
                    n_state = hrct_pkg::S_IDLE;
                end
            end
            default: n_state = hrct_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_req   = '0;
        n_cur   = r_cur;
        n_pred  = r_pred;
        n_head  = r_head;
        n_free  = r_free;
        n_used  = r_used;
        n_cnt   = r_cnt;
        n_rel   = r_rel;
        n_sts   = r_sts;
        o_ready = (r_state == hrct_pkg::S_IDLE) && !i_clr_busy;
        o_req.key_wdata = {r_kv, r_kt};
        case (r_state)
            hrct_pkg::S_IDLE: begin
                o_req.bh_re    = w_accept;
                o_req.bh_raddr = i_item.key_value[hrct_pkg::AW-1:0];
                n_cnt = '0;
                n_rel = 1'b0;
                n_sts = hrct_pkg::ST_OK;
            end
            hrct_pkg::S_HEAD: begin
                n_head = i_rsp.bh_q;
                n_cur  = i_rsp.bh_q;
                n_pred = hrct_pkg::NIL;
                o_req.nd_re    = 1'b1;
                o_req.nd_raddr = (i_rsp.bh_q != hrct_pkg::NIL)
                                 ? i_rsp.bh_q[hrct_pkg::AW-1:0]
                                 : r_free[hrct_pkg::AW-1:0];
                if (i_rsp.bh_q == hrct_pkg::NIL) begin
                    if (r_op == hrct_pkg::OP_RELEASE) begin
                        n_sts = hrct_pkg::ST_RELERR;
                    end else if (w_full) begin
                        n_sts = hrct_pkg::ST_FULL;
                    end
                end
            end
            hrct_pkg::S_NODE: begin
                if (w_match) begin
                    o_req.cnt_waddr = r_cur[hrct_pkg::AW-1:0];
                    case (r_op)
                        hrct_pkg::OP_ADD: begin
                            n_cnt = (i_rsp.cnt_q == hrct_pkg::COUNT_MAX)
                                    ? i_rsp.cnt_q : i_rsp.cnt_q + hrct_pkg::t_count'(1);
                            o_req.cnt_we    = 1'b1;
                            o_req.cnt_wdata = n_cnt;
                        end
                        hrct_pkg::OP_RELEASE: begin
                            if (i_rsp.cnt_q == '0) begin
                                n_sts = hrct_pkg::ST_RELERR;
                            end else begin
                                n_cnt = i_rsp.cnt_q - hrct_pkg::t_count'(1);
                                o_req.cnt_we    = 1'b1;
                                o_req.cnt_wdata = n_cnt;
                                if (i_rsp.cnt_q == hrct_pkg::t_count'(1)) begin
                                    if (r_pred == hrct_pkg::NIL) begin
                                        o_req.bh_we    = 1'b1;
                                        o_req.bh_waddr = r_kv[hrct_pkg::AW-1:0];
                                        o_req.bh_wdata = i_rsp.nxt_q;
                                    end else begin
                                        o_req.nxt_we    = 1'b1;
                                        o_req.nxt_waddr = r_pred[hrct_pkg::AW-1:0];
                                        o_req.nxt_wdata = i_rsp.nxt_q;
                                    end
                                end
                            end
                        end
                        default: n_cnt = i_rsp.cnt_q;
                    endcase
                end else begin
                    n_pred = r_cur;
                    n_cur  = i_rsp.nxt_q;
                    o_req.nd_re    = 1'b1;
                    o_req.nd_raddr = (i_rsp.nxt_q != hrct_pkg::NIL)
                                     ? i_rsp.nxt_q[hrct_pkg::AW-1:0]
                                     : r_free[hrct_pkg::AW-1:0];
                    if (i_rsp.nxt_q == hrct_pkg::NIL) begin
                        if (r_op == hrct_pkg::OP_RELEASE) begin
                            n_sts = hrct_pkg::ST_RELERR;
                        end else if (w_full) begin
                            n_sts = hrct_pkg::ST_FULL;
                        end
                    end
                end
            end
            hrct_pkg::S_INS: begin
                o_req.key_we    = 1'b1;
                o_req.key_waddr = r_free[hrct_pkg::AW-1:0];
                o_req.cnt_we    = 1'b1;
                o_req.cnt_waddr = r_free[hrct_pkg::AW-1:0];
                o_req.cnt_wdata = (r_op == hrct_pkg::OP_ADD) ? hrct_pkg::t_count'(1) : '0;
                o_req.nxt_we    = 1'b1;
                o_req.nxt_waddr = r_free[hrct_pkg::AW-1:0];
                o_req.nxt_wdata = r_head;
                o_req.bh_we     = 1'b1;
                o_req.bh_waddr  = r_kv[hrct_pkg::AW-1:0];
                o_req.bh_wdata  = r_free;
                n_free = i_rsp.nxt_q;
                n_used = r_used + hrct_pkg::t_ptr'(1);
                n_cnt  = o_req.cnt_wdata;
            end
            hrct_pkg::S_FREE: begin
                o_req.nxt_we    = 1'b1;
                o_req.nxt_waddr = r_cur[hrct_pkg::AW-1:0];
                o_req.nxt_wdata = r_free;
                n_free = r_cur;
                n_used = r_used - hrct_pkg::t_ptr'(1);
                n_rel  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hrct_pkg::S_IDLE;
            r_free    <= '0;
            r_used    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_used  <= n_used;
            if (w_done_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_item.operation;
            r_kv <= i_item.key_value;
            r_kt <= i_item.key_type;
        end
        r_cur  <= n_cur;
        r_pred <= n_pred;
        r_head <= n_head;
        r_cnt  <= n_cnt;
        r_rel  <= n_rel;
        r_sts  <= n_sts;
        if (w_done_load) begin
            r_out.ref_count    <= 32'(r_cnt);
            r_out.was_released <= r_rel;
            r_out.status       <= r_sts;
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    `HRCT_ASSERT_ALWAYS(a_used_bound, r_used <= hrct_pkg::t_ptr'(hrct_pkg::SLOTS))
    `HRCT_ASSERT_IMPL(a_free_nonempty, r_state == hrct_pkg::S_FREE, r_used != '0)
    `HRCT_ASSERT_IMPL(a_ins_has_node, r_state == hrct_pkg::S_INS, r_free != hrct_pkg::NIL)
    `HRCT_ASSERT_IMPL(a_rel_zero, r_out_vld && r_out.was_released,
        r_out.ref_count == '0 && r_out.status == hrct_pkg::ST_OK)
endmodule
`default_nettype wire
